/* design/circle_circle_intersection_macros.svh */
// Assertion macros for the circle intersection block
`ifndef CIRCLE_CIRCLE_INTERSECTION_MACROS_SVH
`define CIRCLE_CIRCLE_INTERSECTION_MACROS_SVH

// same-cycle implication
`define CCI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circle intersection assertion failed");

// next-cycle implication
`define CCI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circle intersection assertion failed");

`endif

/* design/cci_pkg.sv */
// Shared widths and stage record types for the circle intersection pipeline
package cci_pkg;

    localparam int CW   = 16;
    localparam int DW   = 17;
    localparam int D2W  = 34;
    localparam int KW   = 36;
    localparam int XW   = 68;
    localparam int RW   = 34;
    localparam int PW   = 53;
    localparam int NW   = 54;
    localparam int DENW = 35;
    localparam int QW   = 17;
    localparam int OW   = 18;
    localparam int SW   = OW + 1;

    typedef struct packed {
        logic                   hit;
        logic signed [CW-1:0]   c1x;
        logic signed [CW-1:0]   c1y;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dy;
        logic [D2W-1:0]         d2;
        logic signed [KW-1:0]   k;
    } geo_t;

    typedef struct packed {
        logic                   hit;
        logic signed [CW-1:0]   c1x;
        logic signed [CW-1:0]   c1y;
        logic                   negx;
        logic                   negy;
        logic [DENW-1:0]        den;
    } div_sb_t;

    typedef struct packed {
        logic                   hit;
        logic signed [CW-1:0]   c1x;
        logic signed [CW-1:0]   c1y;
        logic                   negx;
        logic                   negy;
        logic                   remx_nz;
        logic                   remy_nz;
        logic [QW-1:0]          qx;
        logic [QW-1:0]          qy;
    } quot_t;

endpackage

/* design/cci_front.sv */
// Front stages: deltas, squares, bounds test and the radicand product
module cci_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        src_valid,
    input  logic signed [15:0]          center1_x,
    input  logic signed [15:0]          center1_y,
    input  logic [15:0]                 radius1,
    input  logic signed [15:0]          center2_x,
    input  logic signed [15:0]          center2_y,
    input  logic [15:0]                 radius2,
    output logic                        dst_valid,
    output logic [cci_pkg::XW-1:0]      radicand,
    output cci_pkg::geo_t               geo
);
    import cci_pkg::*;

    logic [4:0]             valid_reg;

    logic signed [CW-1:0]   c1x_s0_reg, c1y_s0_reg;
    logic signed [DW-1:0]   dx_s0_reg, dy_s0_reg;
    logic [CW-1:0]          r1_s0_reg, r2_s0_reg;
    logic signed [DW-1:0]   dx_next, dy_next;

    logic signed [2*DW-1:0] sqx, sqy;
    logic [DW-1:0]          sum;
    logic [CW-1:0]          dif;
    logic [D2W-1:0]         d2_next, sum2_next;
    logic [2*CW-1:0]        r1sq_next, r2sq_next, dif2_next;

    logic signed [CW-1:0]   c1x_s1_reg, c1y_s1_reg;
    logic signed [DW-1:0]   dx_s1_reg, dy_s1_reg;
    logic [D2W-1:0]         d2_s1_reg, sum2_s1_reg;
    logic [2*CW-1:0]        r1sq_s1_reg, r2sq_s1_reg, dif2_s1_reg;

    geo_t                   geo_next, geo_s2_reg, geo_s3_reg, geo_s4_reg;
    logic [D2W-1:0]         a_next, b_next, a_s2_reg, b_s2_reg;

    logic [D2W+16:0]        p0_next, p1_next, p0_s3_reg, p1_s3_reg;
    logic [XW-1:0]          radicand_next, radicand_s4_reg;

    assign dx_next = DW'(center2_x) - DW'(center1_x);
    assign dy_next = DW'(center2_y) - DW'(center1_y);

    assign sqx       = dx_s0_reg * dx_s0_reg;
    assign sqy       = dy_s0_reg * dy_s0_reg;
    assign d2_next   = $unsigned(sqx) + $unsigned(sqy);
    assign sum       = DW'(r1_s0_reg) + DW'(r2_s0_reg);
    assign dif       = (r1_s0_reg >= r2_s0_reg) ? r1_s0_reg - r2_s0_reg
                                                : r2_s0_reg - r1_s0_reg;
    assign sum2_next = D2W'(sum) * D2W'(sum);
    assign dif2_next = dif * dif;
    assign r1sq_next = r1_s0_reg * r1_s0_reg;
    assign r2sq_next = r2_s0_reg * r2_s0_reg;

    always_comb
    begin
        geo_next.hit = (d2_s1_reg != '0) && (d2_s1_reg <= sum2_s1_reg)
                       && (d2_s1_reg >= D2W'(dif2_s1_reg));
        geo_next.c1x = c1x_s1_reg;
        geo_next.c1y = c1y_s1_reg;
        geo_next.dx  = dx_s1_reg;
        geo_next.dy  = dy_s1_reg;
        geo_next.d2  = d2_s1_reg;
        geo_next.k   = KW'(r1sq_s1_reg) - KW'(r2sq_s1_reg) + KW'(d2_s1_reg);
        a_next       = geo_next.hit ? sum2_s1_reg - d2_s1_reg : '0;
        b_next       = geo_next.hit ? d2_s1_reg - D2W'(dif2_s1_reg) : '0;
    end

    assign p0_next       = a_s2_reg * b_s2_reg[16:0];
    assign p1_next       = a_s2_reg * b_s2_reg[D2W-1:17];
    assign radicand_next = XW'(p0_s3_reg) + (XW'(p1_s3_reg) << 17);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], src_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1x_s0_reg      <= center1_x;
            c1y_s0_reg      <= center1_y;
            dx_s0_reg       <= dx_next;
            dy_s0_reg       <= dy_next;
            r1_s0_reg       <= radius1;
            r2_s0_reg       <= radius2;
            c1x_s1_reg      <= c1x_s0_reg;
            c1y_s1_reg      <= c1y_s0_reg;
            dx_s1_reg       <= dx_s0_reg;
            dy_s1_reg       <= dy_s0_reg;
            d2_s1_reg       <= d2_next;
            sum2_s1_reg     <= sum2_next;
            r1sq_s1_reg     <= r1sq_next;
            r2sq_s1_reg     <= r2sq_next;
            dif2_s1_reg     <= dif2_next;
            geo_s2_reg      <= geo_next;
            a_s2_reg        <= a_next;
            b_s2_reg        <= b_next;
            geo_s3_reg      <= geo_s2_reg;
            p0_s3_reg       <= p0_next;
            p1_s3_reg       <= p1_next;
            geo_s4_reg      <= geo_s3_reg;
            radicand_s4_reg <= radicand_next;
        end
    end

    assign dst_valid = valid_reg[4];
    assign radicand  = radicand_s4_reg;
    assign geo       = geo_s4_reg;

endmodule

/* design/cci_isqrt.sv */
// Pipelined integer square root, one result bit per stage
module cci_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        src_valid,
    input  logic [cci_pkg::XW-1:0]      radicand,
    input  cci_pkg::geo_t               src_geo,
    output logic                        dst_valid,
    output logic [cci_pkg::RW-1:0]      root,
    output cci_pkg::geo_t               dst_geo
);
    import cci_pkg::*;

    logic [RW-1:0]  valid_reg;
    logic [XW-1:0]  rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    geo_t           geo_reg  [RW];

    for (genvar j = 0; j < RW; j++)
    begin : g_stage
        localparam int B = RW - 1 - j;
        logic [XW-1:0] rem_in, trial, rem_next;
        logic [RW-1:0] root_in, root_next;
        logic          valid_in;
        geo_t          geo_in;

        if (j == 0)
        begin : g_first
            assign rem_in   = radicand;
            assign root_in  = '0;
            assign valid_in = src_valid;
            assign geo_in   = src_geo;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[j-1];
            assign root_in  = root_reg[j-1];
            assign valid_in = valid_reg[j-1];
            assign geo_in   = geo_reg[j-1];
        end

        assign trial = (XW'(root_in) << (B + 1)) | (XW'(1) << (2 * B));

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (RW'(1) << B);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                geo_reg[j]  <= geo_in;
            end
        end
    end

    assign dst_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign dst_geo   = geo_reg[RW-1];

endmodule

/* design/cci_divide.sv */
// Numerator products and pipelined restoring division by twice the squared distance
module cci_divide (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        src_valid,
    input  logic [cci_pkg::RW-1:0]      root,
    input  cci_pkg::geo_t               geo,
    output logic                        dst_valid,
    output cci_pkg::quot_t              quot
);
    import cci_pkg::*;

    logic signed [PW-1:0]   kdx_next, kdy_next, sdx_next, sdy_next;
    logic signed [PW-1:0]   kdx_reg, kdy_reg, sdx_reg, sdy_reg;
    logic signed [RW:0]     root_s;
    div_sb_t                m_sb_next, m_sb_reg, n_sb_next, n_sb_reg;
    logic [1:0]             valid_mn_reg;

    logic signed [NW-1:0]   nx, ny;
    logic [NW-1:0]          magx_next, magy_next, magx_reg, magy_reg;

    logic [QW-1:0]          valid_reg;
    logic [NW-1:0]          remx_reg [QW];
    logic [NW-1:0]          remy_reg [QW];
    logic [QW-1:0]          qx_reg   [QW];
    logic [QW-1:0]          qy_reg   [QW];
    div_sb_t                sb_reg   [QW];

    assign root_s   = $signed({1'b0, root});
    assign kdx_next = PW'(geo.k) * PW'(geo.dx);
    assign kdy_next = PW'(geo.k) * PW'(geo.dy);
    assign sdx_next = PW'(root_s) * PW'(geo.dx);
    assign sdy_next = PW'(root_s) * PW'(geo.dy);

    always_comb
    begin
        m_sb_next.hit  = geo.hit;
        m_sb_next.c1x  = geo.c1x;
        m_sb_next.c1y  = geo.c1y;
        m_sb_next.negx = 1'b0;
        m_sb_next.negy = 1'b0;
        m_sb_next.den  = {geo.d2, 1'b0};
    end

    assign nx = NW'(kdx_reg) + NW'(sdy_reg);
    assign ny = NW'(kdy_reg) - NW'(sdx_reg);

    always_comb
    begin
        n_sb_next      = m_sb_reg;
        n_sb_next.negx = nx[NW-1];
        n_sb_next.negy = ny[NW-1];
        magx_next      = nx[NW-1] ? $unsigned(-nx) : $unsigned(nx);
        magy_next      = ny[NW-1] ? $unsigned(-ny) : $unsigned(ny);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_mn_reg <= '0;
        end
        else if (en)
        begin
            valid_mn_reg <= {valid_mn_reg[0], src_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kdx_reg  <= kdx_next;
            kdy_reg  <= kdy_next;
            sdx_reg  <= sdx_next;
            sdy_reg  <= sdy_next;
            m_sb_reg <= m_sb_next;
            n_sb_reg <= n_sb_next;
            magx_reg <= magx_next;
            magy_reg <= magy_next;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int B = QW - 1 - j;
        logic [NW-1:0] rx_in, ry_in, rx_next, ry_next, trial;
        logic [QW-1:0] qx_in, qy_in, qx_next, qy_next;
        logic          valid_in;
        div_sb_t       sb_in;

        if (j == 0)
        begin : g_first
            assign rx_in    = magx_reg;
            assign ry_in    = magy_reg;
            assign qx_in    = '0;
            assign qy_in    = '0;
            assign valid_in = valid_mn_reg[1];
            assign sb_in    = n_sb_reg;
        end
        else
        begin : g_rest
            assign rx_in    = remx_reg[j-1];
            assign ry_in    = remy_reg[j-1];
            assign qx_in    = qx_reg[j-1];
            assign qy_in    = qy_reg[j-1];
            assign valid_in = valid_reg[j-1];
            assign sb_in    = sb_reg[j-1];
        end

        assign trial = NW'(sb_in.den) << B;

        always_comb
        begin
            if (rx_in >= trial)
            begin
                rx_next = rx_in - trial;
                qx_next = qx_in | (QW'(1) << B);
            end
            else
            begin
                rx_next = rx_in;
                qx_next = qx_in;
            end
            if (ry_in >= trial)
            begin
                ry_next = ry_in - trial;
                qy_next = qy_in | (QW'(1) << B);
            end
            else
            begin
                ry_next = ry_in;
                qy_next = qy_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                remx_reg[j] <= rx_next;
                remy_reg[j] <= ry_next;
                qx_reg[j]   <= qx_next;
                qy_reg[j]   <= qy_next;
                sb_reg[j]   <= sb_in;
            end
        end
    end

    always_comb
    begin
        quot.hit     = sb_reg[QW-1].hit;
        quot.c1x     = sb_reg[QW-1].c1x;
        quot.c1y     = sb_reg[QW-1].c1y;
        quot.negx    = sb_reg[QW-1].negx;
        quot.negy    = sb_reg[QW-1].negy;
        quot.remx_nz = (remx_reg[QW-1] != '0);
        quot.remy_nz = (remy_reg[QW-1] != '0);
        quot.qx      = qx_reg[QW-1];
        quot.qy      = qy_reg[QW-1];
    end

    assign dst_valid = valid_reg[QW-1];

endmodule

/* design/circle_circle_intersection.sv */
// Circle intersection top level: front, square root, division and result register
// Takes one request per clock while the result side does not stall and returns one result
// per request, in order, through 5 front stages, 34 square-root stages (one root bit each),
// 2 product stages, 17 division stages (one quotient bit each) and the result register.
// A stall on the result side freezes the whole pipeline, so request_stall follows
// result_stall while a result is held.
module circle_circle_intersection (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_stall,
    input  logic signed [15:0]  center1_x,
    input  logic signed [15:0]  center1_y,
    input  logic [15:0]         radius1,
    input  logic signed [15:0]  center2_x,
    input  logic signed [15:0]  center2_y,
    input  logic [15:0]         radius2,
    output logic                result_valid,
    input  logic                result_stall,
    output logic                intersects,
    output logic signed [17:0]  point_x,
    output logic signed [17:0]  point_y
);
    import cci_pkg::*;

    logic               en;
    logic               front_valid, sqrt_valid, div_valid;
    logic [XW-1:0]      radicand;
    logic [RW-1:0]      root;
    geo_t               front_geo, sqrt_geo;
    quot_t              quot;

    logic signed [SW-1:0]   offx, offy, sumx, sumy;
    logic signed [OW-1:0]   satx, saty;

    logic                   result_valid_reg;
    logic                   intersects_reg;
    logic signed [OW-1:0]   point_x_reg, point_y_reg;

    assign en            = !result_valid_reg || !result_stall;
    assign request_stall = !en;

    cci_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (request_valid),
        .center1_x (center1_x),
        .center1_y (center1_y),
        .radius1   (radius1),
        .center2_x (center2_x),
        .center2_y (center2_y),
        .radius2   (radius2),
        .dst_valid (front_valid),
        .radicand  (radicand),
        .geo       (front_geo)
    );

    cci_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (front_valid),
        .radicand  (radicand),
        .src_geo   (front_geo),
        .dst_valid (sqrt_valid),
        .root      (root),
        .dst_geo   (sqrt_geo)
    );

    cci_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (sqrt_valid),
        .root      (root),
        .geo       (sqrt_geo),
        .dst_valid (div_valid),
        .quot      (quot)
    );

    // floor the quotient for negative numerators
    assign offx = quot.negx ? -SW'(quot.qx) - SW'(quot.remx_nz) : SW'(quot.qx);
    assign offy = quot.negy ? -SW'(quot.qy) - SW'(quot.remy_nz) : SW'(quot.qy);
    assign sumx = SW'(quot.c1x) + offx;
    assign sumy = SW'(quot.c1y) + offy;

    always_comb
    begin
        if (sumx[SW-1] != sumx[SW-2])
            satx = sumx[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        else
            satx = sumx[OW-1:0];
        if (sumy[SW-1] != sumy[SW-2])
            saty = sumy[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        else
            saty = sumy[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            intersects_reg <= quot.hit;
            point_x_reg    <= quot.hit ? satx : OW'(quot.c1x);
            point_y_reg    <= quot.hit ? saty : OW'(quot.c1y);
        end
    end

    assign result_valid = result_valid_reg;
    assign intersects   = intersects_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;

endmodule

/* design/cci_checker.sv */
// Port-level checker for the circle intersection block and its bind
`include "circle_circle_intersection_macros.svh"

module cci_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 request_valid,
    input logic                 request_stall,
    input logic signed [15:0]   center1_x,
    input logic signed [15:0]   center1_y,
    input logic [15:0]          radius1,
    input logic signed [15:0]   center2_x,
    input logic signed [15:0]   center2_y,
    input logic [15:0]          radius2,
    input logic                 result_valid,
    input logic                 result_stall,
    input logic                 intersects,
    input logic signed [17:0]   point_x,
    input logic signed [17:0]   point_y
);

    logic           req_waiting;
    logic           res_waiting;
    logic [95:0]    req_bits;
    logic [36:0]    res_bits;

    assign req_waiting = request_valid && request_stall;
    assign res_waiting = result_valid && result_stall;
    assign req_bits    = {center1_x, center1_y, radius1, center2_x, center2_y, radius2};
    assign res_bits    = {intersects, point_x, point_y};

    `CCI_ASSERT_IMP(a_stall_only_when_full, request_stall, result_valid && result_stall)

    `CCI_ASSERT_NXT(a_stalled_result_held, res_waiting, result_valid && $stable(res_bits))

    `CCI_ASSERT_NXT(a_stalled_request_held, req_waiting, request_valid && $stable(req_bits))

    `CCI_ASSERT_IMP(a_result_not_dropped, $fell(result_valid), !$past(result_stall))

endmodule

bind circle_circle_intersection cci_checker u_cci_checker (.*);
